>>> design/polygon_moment_accumulator_macros.svh
// Assertion macros for the polygon moment accumulator.
// Used by the modules that carry concurrent assertions; no dependencies.
`ifndef POLYGON_MOMENT_ACCUMULATOR_MACROS_SVH
`define POLYGON_MOMENT_ACCUMULATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define PMA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pma assertion failed");

// next-cycle implication, disabled in reset
`define PMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pma assertion failed");

`endif

>>> design/pma_pkg.sv
// Package for the polygon moment accumulator: widths, payload structs
// and the edge record passed from the front end to the back end. No dependencies.
package pma_pkg;

  localparam int COORD_BITS  = 12;
  localparam int IN_W        = 12;
  localparam int SUM_W       = 64;
  localparam int D_W         = COORD_BITS + 1;   // signed coordinate / delta
  localparam int P_W         = 2 * COORD_BITS + 2; // first-level products
  localparam int A_W         = P_W + 1;          // edge cross term
  localparam int F_W         = P_W + 3;          // moment weights
  localparam int M_W         = A_W + F_W;        // full term product
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [IN_W-1:0] px;
    logic [IN_W-1:0] py;
    logic            last;
  } vertex_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] area_x2;
    logic signed [SUM_W-1:0] mom_x_x6;
    logic signed [SUM_W-1:0] mom_y_x6;
    logic signed [SUM_W-1:0] mom_xy_x24;
    logic signed [SUM_W-1:0] mom_xx_x12;
    logic signed [SUM_W-1:0] mom_yy_x12;
  } moments_t;

  // edge from (xj,yj) to (x,y); emit closes the contour
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t xj;
    coord_t yj;
    logic   emit;
  } edge_t;

endpackage

>>> design/pma_queue.sv
// Short edge queue between the front end and the back end.
// Depends on pma_pkg.
module pma_queue import pma_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  edge_t push_edge,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output edge_t head
);

  edge_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/pma_front.sv
// Front end: accepts vertices, tracks first/previous vertex and turns each
// vertex into edge records for the queue. Depends on pma_pkg.
module pma_front import pma_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    vtx_valid,
  output logic    vtx_ready,
  input  vertex_t vtx,
  output logic    push,
  output edge_t   push_edge,
  input  logic    q_full
);

  coord_t first_x;
  coord_t first_y;
  coord_t prev_x;
  coord_t prev_y;
  logic   started;
  logic   pend;
  edge_t  pend_edge;

  coord_t x;
  coord_t y;
  logic   acc;

  assign x         = vtx.px[COORD_BITS-1:0];
  assign y         = vtx.py[COORD_BITS-1:0];
  assign vtx_ready = !pend && !q_full;
  assign acc       = vtx_valid && vtx_ready;

  always_comb begin
    push      = 1'b0;
    push_edge = pend_edge;
    if (pend) begin
      push = !q_full;
    end else if (acc) begin
      if (started) begin
        push      = 1'b1;
        push_edge = '{x: x, y: y, xj: prev_x, yj: prev_y, emit: 1'b0};
      end else if (vtx.last) begin
        // lone vertex: degenerate closing edge
        push      = 1'b1;
        push_edge = '{x: x, y: y, xj: x, yj: y, emit: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && started && vtx.last) begin
      pend_edge <= '{x: first_x, y: first_y, xj: x, yj: y, emit: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x <= '0;
      first_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
      started <= 1'b0;
      pend    <= 1'b0;
    end else begin
      if (pend && !q_full) begin
        pend <= 1'b0;
      end
      if (acc) begin
        prev_x <= x;
        prev_y <= y;
        if (!started) begin
          first_x <= x;
          first_y <= y;
          started <= !vtx.last;
        end else if (vtx.last) begin
          started <= 1'b0;
          pend    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/pma_back.sv
// Back end: four-stage edge-term pipeline, running sums and result register.
// Depends on pma_pkg and polygon_moment_accumulator_macros.svh.
`include "polygon_moment_accumulator_macros.svh"

module pma_back import pma_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  edge_t    head,
  output logic     pop,
  output logic     mom_valid,
  input  logic     mom_ready,
  output moments_t mom
);

  logic adv;
  logic [3:0] v;
  logic [3:0] em;

  // stage 1: coordinates and deltas
  logic signed [D_W-1:0] xs1, ys1, dx1, dy1;
  // stage 2: products
  logic signed [P_W-1:0] p_xdy, p_ydx, p_xy, p_xx, p_yy;
  logic signed [P_W-1:0] p_dxdy, p_xdx, p_ydy, p_dxdx, p_dydy;
  logic signed [F_W-1:0] f_mx2, f_my2;
  // stage 3: cross term and weights
  logic signed [A_W-1:0] a3;
  logic signed [F_W-1:0] f_mx3, f_my3, f_mxy3, f_mxx3, f_myy3;
  // stage 4: terms
  moments_t t4;
  moments_t sums;
  moments_t sums_next;

  assign adv = !mom_valid || mom_ready;
  assign pop = adv && q_valid;

  always_comb begin
    sums_next.area_x2    = sums.area_x2 + t4.area_x2;
    sums_next.mom_x_x6   = sums.mom_x_x6 + t4.mom_x_x6;
    sums_next.mom_y_x6   = sums.mom_y_x6 + t4.mom_y_x6;
    sums_next.mom_xy_x24 = sums.mom_xy_x24 + t4.mom_xy_x24;
    sums_next.mom_xx_x12 = sums.mom_xx_x12 + t4.mom_xx_x12;
    sums_next.mom_yy_x12 = sums.mom_yy_x12 + t4.mom_yy_x12;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xs1 <= $signed({1'b0, head.x});
      ys1 <= $signed({1'b0, head.y});
      dx1 <= $signed({1'b0, head.x}) - $signed({1'b0, head.xj});
      dy1 <= $signed({1'b0, head.y}) - $signed({1'b0, head.yj});

      p_xdy  <= P_W'(xs1) * P_W'(dy1);
      p_ydx  <= P_W'(ys1) * P_W'(dx1);
      p_xy   <= P_W'(xs1) * P_W'(ys1);
      p_xx   <= P_W'(xs1) * P_W'(xs1);
      p_yy   <= P_W'(ys1) * P_W'(ys1);
      p_dxdy <= P_W'(dx1) * P_W'(dy1);
      p_xdx  <= P_W'(xs1) * P_W'(dx1);
      p_ydy  <= P_W'(ys1) * P_W'(dy1);
      p_dxdx <= P_W'(dx1) * P_W'(dx1);
      p_dydy <= P_W'(dy1) * P_W'(dy1);
      f_mx2  <= (F_W'(xs1) <<< 1) - F_W'(dx1);
      f_my2  <= (F_W'(ys1) <<< 1) - F_W'(dy1);

      a3     <= A_W'(p_xdy) - A_W'(p_ydx);
      f_mx3  <= f_mx2;
      f_my3  <= f_my2;
      f_mxy3 <= F_W'(6) * F_W'(p_xy) - F_W'(3) * F_W'(p_xdy)
                - F_W'(3) * F_W'(p_ydx) + (F_W'(p_dxdy) <<< 1);
      f_mxx3 <= F_W'(3) * F_W'(p_xx) - F_W'(3) * F_W'(p_xdx) + F_W'(p_dxdx);
      f_myy3 <= F_W'(3) * F_W'(p_yy) - F_W'(3) * F_W'(p_ydy) + F_W'(p_dydy);

      t4.area_x2    <= SUM_W'(a3);
      t4.mom_x_x6   <= SUM_W'(M_W'(a3) * M_W'(f_mx3));
      t4.mom_y_x6   <= SUM_W'(M_W'(a3) * M_W'(f_my3));
      t4.mom_xy_x24 <= SUM_W'(M_W'(a3) * M_W'(f_mxy3));
      t4.mom_xx_x12 <= SUM_W'(M_W'(a3) * M_W'(f_mxx3));
      t4.mom_yy_x12 <= SUM_W'(M_W'(a3) * M_W'(f_myy3));

      em <= {em[2:0], head.emit};

      if (v[3] && em[3]) begin
        mom <= sums_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      sums      <= '0;
      mom_valid <= 1'b0;
    end else begin
      if (mom_valid && mom_ready) begin
        mom_valid <= 1'b0;
      end
      if (adv) begin
        v <= {v[2:0], pop};
        if (v[3]) begin
          if (em[3]) begin
            sums      <= '0;
            mom_valid <= 1'b1;
          end else begin
            sums <= sums_next;
          end
        end
      end
    end
  end

  `PMA_ASSERT_NEXT(a_sums_cleared, clk, rst, adv && v[3] && em[3], sums == '0)
  `PMA_ASSERT_NEXT(a_stall_holds, clk, rst, !adv, $stable(v))
  `PMA_ASSERT_NOW(a_result_from_close, clk, rst, $rose(mom_valid), $past(v[3] && em[3]))

endmodule

>>> design/polygon_moment_accumulator.sv
// Polygon moment accumulator top level: front end, edge queue, back end.
// Depends on pma_pkg, pma_front, pma_queue and pma_back.
//
//   channel  | handshake             | payload
//   vertex   | vtx_valid / vtx_ready | vtx (vertex_t: px, py, last)
//   moments  | mom_valid / mom_ready | mom (moments_t: six 64-bit sums)
//
// One vertex per cycle while the queue has room and no closing edge is pending;
// a closing vertex of a contour of two or more vertices queues its edge, then
// the closing edge, before the next vertex. The back end takes one edge per cycle
// unless the result stalls; its edges pass the four-entry queue and pipeline to mom.
// A stalled result freezes the back end; the queue then fills and vtx_ready falls.
// Synchronous reset clears the contour state, sums, queue and pipeline.
module polygon_moment_accumulator import pma_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     vtx_valid,
  output logic     vtx_ready,
  input  vertex_t  vtx,
  output logic     mom_valid,
  input  logic     mom_ready,
  output moments_t mom
);

  logic  push;
  edge_t push_edge;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  edge_t head;

  pma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .push      (push),
    .push_edge (push_edge),
    .q_full    (q_full)
  );

  pma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_edge (push_edge),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  pma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .mom_valid (mom_valid),
    .mom_ready (mom_ready),
    .mom       (mom)
  );

endmodule
